@@ design/ultrasonic_echo_ranger_core_assert.svh @@
// Assertion macros for the echo ranger checker.
// Needs no package; the caller passes clock, reset and expressions.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_ASSERT_SVH

// Same-cycle implication, quiet while reset is applied.
`define UER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("echo ranger assertion failed");

// Next-cycle implication, quiet while reset is applied.
`define UER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("echo ranger assertion failed");

`endif

@@ design/uer_pkg.sv @@
// Shared types and constants of the echo ranger.
// No dependencies; the skid, core and checker import it, uer_out_if uses it.
package uer_pkg;

  localparam int unsigned CFG_W    = 24;  // period, gap and delay registers
  localparam int unsigned TRIG_W   = 8;   // trigger width register
  localparam int unsigned WIDTH_W  = 24;  // echo_width_us field
  localparam int unsigned DIST_W   = 22;  // obj_dist_mm field
  localparam int unsigned ADDR_W   = 4;   // four word-aligned registers
  localparam int unsigned DATA_W   = 32;

  // distance = width*10/58 = width*5/29, kept as running quotient/remainder
  localparam int unsigned DIST_NUM = 5;
  localparam int unsigned DIST_DEN = 29;
  localparam int unsigned REM_W    = 5;   // remainder stays below DIST_DEN

  localparam logic [CFG_W-1:0]  PERIOD_RST = CFG_W'(60000);
  localparam logic [CFG_W-1:0]  GAP_RST    = CFG_W'(1000);
  localparam logic [TRIG_W-1:0] TRIGW_RST  = TRIG_W'(10);
  localparam logic [CFG_W-1:0]  FIRST_RST  = CFG_W'(1000);

  typedef enum logic [1:0] {
    CFG_PERIOD = 2'd0,
    CFG_GAP    = 2'd1,
    CFG_TRIGW  = 2'd2,
    CFG_FIRST  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               trigger_level;
    logic               result_valid;
    logic [WIDTH_W-1:0] echo_width_us;
    logic [DIST_W-1:0]  obj_dist_mm;
  } result_t;

endpackage

@@ design/uer_in_if.sv @@
// Input channel of the echo ranger: one sampled echo level per word.
// Depends on nothing.
interface uer_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

@@ design/uer_out_if.sv @@
// Result channel of the echo ranger.
// Depends on uer_pkg for the field widths.
interface uer_out_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger_level;
  logic                       result_valid;
  logic [uer_pkg::WIDTH_W-1:0] echo_width_us;
  logic [uer_pkg::DIST_W-1:0]  obj_dist_mm;

  modport source (output valid, output trigger_level, output result_valid,
                  output echo_width_us, output obj_dist_mm, input ready);
  modport sink   (input valid, input trigger_level, input result_valid,
                  input echo_width_us, input obj_dist_mm, output ready);
endinterface

@@ design/uer_skid.sv @@
// Output register plus skid stage for result words.
// Depends on uer_pkg for result_t.
module uer_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  uer_pkg::result_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output uer_pkg::result_t out_data_o
);
  import uer_pkg::*;

  logic    out_v_q, skid_v_q;
  result_t out_data_q, skid_data_q;
  logic    drain;

  assign drain       = !out_v_q || out_ready_i;
  assign in_ready_o  = !skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (drain) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      if (skid_v_q) begin
        out_data_q <= skid_data_q;
      end else if (in_valid_i) begin
        out_data_q <= in_data_i;
      end
    end else if (in_valid_i && !skid_v_q) begin
      skid_data_q <= in_data_i;
    end
  end

endmodule

@@ design/ultrasonic_echo_ranger_core.sv @@
// Echo ranger top level: trigger sequencer, echo timer and APB registers.
// An accepted word is registered in the output register, or in the skid stage.
// Throughput: one word per cycle; the output register and a skid stage keep
// accepting while a single result waits, input ready drops only when both are full.
// Reset: asynchronous, active low; registers return to 60000/1000/10/1000 and the
// first trigger is due 1000 ticks after reset.
module ultrasonic_echo_ranger_core #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  uer_in_if.sink                      echo_if_i,
  uer_out_if.source                   result_if_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uer_pkg::ADDR_W-1:0]  paddr,
  input  logic [uer_pkg::DATA_W-1:0]  pwdata,
  output logic [uer_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import uer_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers. Only the register index bits of paddr decode.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0]  period_q, gap_q, first_q;
  logic [TRIG_W-1:0] trigw_q;
  cfg_idx_e          cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      gap_q    <= GAP_RST;
      trigw_q  <= TRIGW_RST;
      first_q  <= FIRST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_PERIOD: period_q <= pwdata[CFG_W-1:0];
        CFG_GAP:    gap_q    <= pwdata[CFG_W-1:0];
        CFG_TRIGW:  trigw_q  <= pwdata[TRIG_W-1:0];
        CFG_FIRST:  first_q  <= pwdata[CFG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_PERIOD: prdata = DATA_W'(period_q);
      CFG_GAP:    prdata = DATA_W'(gap_q);
      CFG_TRIGW:  prdata = DATA_W'(trigw_q);
      CFG_FIRST:  prdata = DATA_W'(first_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Ranging state. The distance of the running width is tracked as a quotient
  // and remainder of width*5/29, so a falling edge latches it with no divider.
  // The first-delay register only matters at reset, where it equals its reset
  // value, so the wait countdown resets straight to that constant.
  // ---------------------------------------------------------------------------
  logic                   echo_prev_q, echo_prev_d;
  logic [COUNT_WIDTH-1:0] wcnt_q, wcnt_d;
  logic [COUNT_WIDTH-1:0] dquo_q, dquo_d;
  logic [REM_W-1:0]       drem_q, drem_d;
  logic [COUNT_WIDTH-1:0] lw_q, lw_d;
  logic [COUNT_WIDTH-1:0] ld_q, ld_d;
  logic [CFG_W-1:0]       wait_q, wait_d;
  logic                   pend_q, pend_d;
  logic [TRIG_W-1:0]      pulse_q, pulse_d;

  logic                   accept;
  logic                   echo;
  logic                   trig;
  logic                   edge_flag;
  logic [REM_W:0]         rsum;
  logic [DATA_W-1:0]      wcnt_ext, period_ext, lw_ext, ld_ext;
  result_t                res;

  assign accept     = echo_if_i.valid && echo_if_i.ready;
  assign echo       = echo_if_i.echo_level;
  assign rsum       = {1'b0, drem_q} + (REM_W + 1)'(DIST_NUM);
  assign wcnt_ext   = DATA_W'(wcnt_q);
  assign period_ext = DATA_W'(period_q);

  always_comb begin
    echo_prev_d = echo;
    wcnt_d      = wcnt_q;
    dquo_d      = dquo_q;
    drem_d      = drem_q;
    lw_d        = lw_q;
    ld_d        = ld_q;
    wait_d      = wait_q;
    pend_d      = pend_q;
    pulse_d     = pulse_q;
    edge_flag   = 1'b0;
    trig        = (pulse_q != '0);

    // Trigger side: run down the pulse, then end a pending wait.
    if (pulse_q != '0) begin
      pulse_d = pulse_q - 1'b1;
    end
    if (pend_q) begin
      if (wait_q <= CFG_W'(1)) begin
        pend_d  = 1'b0;
        pulse_d = trigw_q;
      end else begin
        wait_d = wait_q - 1'b1;
      end
    end

    // Echo side: time the high phase, latch on the falling edge.
    priority if (echo && !echo_prev_q) begin
      wcnt_d = COUNT_WIDTH'(1);
      dquo_d = '0;
      drem_d = REM_W'(DIST_NUM);
    end else if (echo) begin
      if (!(&wcnt_q)) begin
        wcnt_d = wcnt_q + 1'b1;
        if (rsum >= (REM_W + 1)'(DIST_DEN)) begin
          drem_d = REM_W'(rsum - (REM_W + 1)'(DIST_DEN));
          dquo_d = dquo_q + 1'b1;
        end else begin
          drem_d = rsum[REM_W-1:0];
        end
      end
    end else if (echo_prev_q) begin
      lw_d      = wcnt_q;
      ld_d      = dquo_q;
      edge_flag = 1'b1;
      // A wait already under way keeps running untouched.
      if (!pend_d) begin
        if (wcnt_ext < period_ext) begin
          wait_d = period_q - wcnt_ext[CFG_W-1:0];
        end else begin
          wait_d = gap_q;
        end
        pend_d = 1'b1;
      end
    end else begin
      // echo idle low: hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_prev_q <= 1'b0;
      wcnt_q      <= '0;
      dquo_q      <= '0;
      drem_q      <= '0;
      lw_q        <= '0;
      ld_q        <= '0;
      wait_q      <= FIRST_RST;
      pend_q      <= 1'b1;
      pulse_q     <= '0;
    end else if (accept) begin
      echo_prev_q <= echo_prev_d;
      wcnt_q      <= wcnt_d;
      dquo_q      <= dquo_d;
      drem_q      <= drem_d;
      lw_q        <= lw_d;
      ld_q        <= ld_d;
      wait_q      <= wait_d;
      pend_q      <= pend_d;
      pulse_q     <= pulse_d;
    end
  end

  // Mask the latched values to the field widths of the result word.
  assign lw_ext = DATA_W'(lw_d);
  assign ld_ext = DATA_W'(ld_d);

  always_comb begin
    res.trigger_level = trig;
    res.result_valid  = edge_flag;
    res.echo_width_us = lw_ext[WIDTH_W-1:0];
    res.obj_dist_mm   = ld_ext[DIST_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Result register and skid stage.
  // ---------------------------------------------------------------------------
  result_t out_word;

  uer_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (echo_if_i.valid),
    .in_ready_o  (echo_if_i.ready),
    .in_data_i   (res),
    .out_valid_o (result_if_o.valid),
    .out_ready_i (result_if_o.ready),
    .out_data_o  (out_word)
  );

  assign result_if_o.trigger_level = out_word.trigger_level;
  assign result_if_o.result_valid  = out_word.result_valid;
  assign result_if_o.echo_width_us = out_word.echo_width_us;
  assign result_if_o.obj_dist_mm   = out_word.obj_dist_mm;

endmodule

@@ design/uer_checker.sv @@
// Port-level checker for the echo ranger, bound to the top level.
// Depends on uer_pkg and the assertion macro header.
`include "ultrasonic_echo_ranger_core_assert.svh"

module uer_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_trig_i,
  input logic                        out_flag_i,
  input logic [uer_pkg::WIDTH_W-1:0] out_width_i,
  input logic [uer_pkg::DIST_W-1:0]  out_dist_i
);
  import uer_pkg::*;

  logic                          stalled;
  logic                          skid_fill;
  logic [WIDTH_W+DIST_W+1:0]     out_word;

  assign stalled   = out_valid_i && !out_ready_i;
  assign skid_fill = stalled && in_valid_i;
  assign out_word  = {out_trig_i, out_flag_i, out_width_i, out_dist_i};

  // A stalled result word holds.
  `UER_ASSERT_NXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_i && $stable(out_word))

  // Input back-pressure only while a result word is waiting.
  `UER_ASSERT_IMP(a_ready_needs_out, clk_i, rst_ni, !in_ready_i, out_valid_i)

  // The skid stage only fills after a stalled output met a valid input word.
  `UER_ASSERT_IMP(a_ready_after_stall, clk_i, rst_ni, $fell(in_ready_i), $past(skid_fill))

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (echo_if_i.valid),
  .in_ready_i  (echo_if_i.ready),
  .out_valid_i (result_if_o.valid),
  .out_ready_i (result_if_o.ready),
  .out_trig_i  (result_if_o.trigger_level),
  .out_flag_i  (result_if_o.result_valid),
  .out_width_i (result_if_o.echo_width_us),
  .out_dist_i  (result_if_o.obj_dist_mm)
);

@@ verif/tb_ultrasonic_echo_ranger_core.sv @@
// Self-checking testbench for the ultrasonic echo ranger core.
// Depends on uer_pkg, uer_in_if and uer_out_if from the design folder and on the
// core itself; predicts the result words from its own model, but for typed probe rows.
module tb_ultrasonic_echo_ranger_core;
  import uer_pkg::*;

  localparam int          CNT_W    = 24;
  localparam int          HALF_PER = 5;
  localparam int          LIMIT_TU = 6_000_000;
  localparam int          PROBE_N  = 20;
  localparam int unsigned TAIL_CYC = 8;

  localparam logic [CFG_W-1:0]  CFG_TOP   = '1;
  localparam logic [TRIG_W-1:0] TRIGW_TOP = '1;
  localparam logic [CNT_W-1:0]  CNT_TOP   = '1;

  // One row of the directed table: echo level for the tick, and the result word
  // typed in by hand where it is obvious; other rows go through the predictor.
  typedef struct packed {
    logic    echo;
    logic    typed;
    result_t want;
  } probe_row_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  uer_in_if  echo_if ();
  uer_out_if res_if ();

  ultrasonic_echo_ranger_core #(
    .COUNT_WIDTH (CNT_W)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .echo_if_i   (echo_if),
    .result_if_o (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(HALF_PER) clk_i = ~clk_i;

  // Register copies held by the testbench, updated after each set of APB writes.
  logic [CFG_W-1:0]  period_q = PERIOD_RST;
  logic [CFG_W-1:0]  gap_q    = GAP_RST;
  logic [TRIG_W-1:0] trigw_q  = TRIGW_RST;
  logic [CFG_W-1:0]  first_q  = FIRST_RST;  // only acts at reset, kept for readback

  // Ranger state as the predictor sees it, starting from the reset values.
  logic              echo_seen  = 1'b0;
  logic [CNT_W-1:0]  high_ticks = '0;
  logic [WIDTH_W-1:0] held_width = '0;
  logic [DIST_W-1:0] held_dist  = '0;
  logic [CFG_W-1:0]  wait_left  = FIRST_RST;  // reset happens once, before any write
  logic              wait_armed = 1'b1;
  logic [TRIG_W-1:0] pulse_left = '0;

  result_t     pending_readings [$];
  int unsigned words_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned reg_faults  = 0;
  logic        calm_q      = 1'b0;  // high: no gaps and no stalls on either side
  int unsigned stall_left  = 0;

  // Directed ticks right after reset. The first trigger is 1000 ticks away, so the
  // trigger stays low and every falling edge finds a wait already pending.
  probe_row_t probe_tab [PROBE_N] = '{
    '{1'b0, 1'b1, '{1'b0, 1'b0, 24'd0, 22'd0}},  // reset state
    '{1'b1, 1'b1, '{1'b0, 1'b0, 24'd0, 22'd0}},  // rising edge, nothing latched
    '{1'b0, 1'b1, '{1'b0, 1'b1, 24'd1, 22'd0}},  // shortest echo
    '{1'b0, 1'b1, '{1'b0, 1'b0, 24'd1, 22'd0}},  // width held between edges
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b1, '{1'b0, 1'b1, 24'd6, 22'd1}},  // first width with a distance of 1
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b1, '{1'b0, 1'b1, 24'd1, 22'd0}},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b1, '{1'b0, 1'b1, 24'd3, 22'd0}},
    '{1'b0, 1'b0, '0},
    '{1'b1, 1'b0, '0},
    '{1'b0, 1'b1, '{1'b0, 1'b1, 24'd1, 22'd0}}
  };

  // Advance the ranger by one tick: trigger stage first, then the echo stage.
  function automatic result_t ranger_tick(input logic echo);
    result_t r;
    r.trigger_level = (pulse_left != '0);
    r.result_valid  = 1'b0;
    if (pulse_left != '0)
      pulse_left--;
    // a wait of zero behaves as one tick; ending it reloads even a running pulse
    if (wait_armed) begin
      if (wait_left <= 1) begin
        wait_armed = 1'b0;
        pulse_left = trigw_q;
      end else begin
        wait_left--;
      end
    end
    if (echo && !echo_seen) begin
      high_ticks = CNT_W'(1);
    end else if (echo) begin
      if (high_ticks != CNT_TOP)
        high_ticks++;
    end else if (echo_seen) begin
      held_width = WIDTH_W'(high_ticks);
      held_dist  = DIST_W'((34'(held_width) * DIST_NUM) / DIST_DEN);
      r.result_valid = 1'b1;
      // leave a pending wait alone; else schedule the next trigger
      if (!wait_armed) begin
        wait_left  = (held_width < period_q) ? period_q - held_width : gap_q;
        wait_armed = 1'b1;
      end
    end
    echo_seen = echo;
    r.echo_width_us = held_width;
    r.obj_dist_mm   = held_dist;
    return r;
  endfunction

  // Gap length shared by both sides: mostly none, some short, a few long.
  function automatic int unsigned idle_len();
    int unsigned roll;
    if (calm_q)
      return 0;
    roll = $urandom_range(99, 0);
    if (roll < 70)
      return 0;
    else if (roll < 96)
      return $urandom_range(3, 1);
    else
      return $urandom_range(30, 8);
  endfunction

  // Stall the result channel at random.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left--;
    end else begin
      res_if.ready <= 1'b1;
      stall_left = idle_len();
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_readings.size() == 0) begin
        $error("result word accepted with no prediction waiting");
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (res_if.trigger_level !== want.trigger_level) begin
          $error("trigger_level: expected %0d, got %0d", want.trigger_level,
                 res_if.trigger_level);
          mismatches++;
        end
        if (res_if.result_valid !== want.result_valid) begin
          $error("result_valid: expected %0d, got %0d", want.result_valid,
                 res_if.result_valid);
          mismatches++;
        end
        if (res_if.echo_width_us !== want.echo_width_us) begin
          $error("echo_width_us: expected %0d, got %0d", want.echo_width_us,
                 res_if.echo_width_us);
          mismatches++;
        end
        if (res_if.obj_dist_mm !== want.obj_dist_mm) begin
          $error("obj_dist_mm: expected %0d, got %0d", want.obj_dist_mm,
                 res_if.obj_dist_mm);
          mismatches++;
        end
      end
    end
  end

  // Send one echo word after a random gap; predict it once accepted.
  task automatic send_word(input logic lvl, input logic typed, input result_t want);
    int unsigned gap;
    result_t     got;
    gap = idle_len();
    if (gap != 0) begin
      echo_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    echo_if.valid      <= 1'b1;
    echo_if.echo_level <= lvl;
    do @(posedge clk_i); while (!echo_if.ready);
    got = ranger_tick(lvl);
    pending_readings.push_back(typed ? want : got);
    words_sent++;
  endtask

  // Drop valid, then hold until every prediction has been matched.
  task automatic drain();
    echo_if.valid <= 1'b0;
    while (pending_readings.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYC) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic reg_write(input cfg_idx_e idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // APB read, checked against the register copy.
  task automatic reg_readback(input cfg_idx_e idx, input logic [DATA_W-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== want) begin
      $error("prdata %s: expected %0d, got %0d", idx.name(), want, prdata);
      reg_faults++;
    end
  endtask

  // Write all four registers with junk above each field, then read them back.
  task automatic program_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] gap,
                              input logic [TRIG_W-1:0] trigw, input logic [CFG_W-1:0] first);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    reg_write(CFG_PERIOD, {junk[DATA_W-1:CFG_W], period});
    reg_write(CFG_GAP,    {junk[DATA_W-1:CFG_W], gap});
    reg_write(CFG_TRIGW,  {junk[DATA_W-1:TRIG_W], trigw});
    reg_write(CFG_FIRST,  {junk[DATA_W-1:CFG_W], first});
    period_q = period;
    gap_q    = gap;
    trigw_q  = trigw;
    first_q  = first;
    reg_readback(CFG_PERIOD, DATA_W'(period_q));
    reg_readback(CFG_GAP,    DATA_W'(gap_q));
    reg_readback(CFG_TRIGW,  DATA_W'(trigw_q));
    reg_readback(CFG_FIRST,  DATA_W'(first_q));
  endtask

  // Random echo traffic: mostly clean pulses of random width, some echoes longer
  // than the period, and bursts of noise. Flip the calm mode now and then.
  task automatic run_phase(input int unsigned n);
    int unsigned stop_at;
    int unsigned lo;
    int unsigned hi;
    int unsigned roll;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      roll = $urandom_range(99, 0);
      if ($urandom_range(11, 0) == 0)
        calm_q <= !calm_q;
      if (roll < 10) begin
        lo = $urandom_range(12, 1);
        repeat (lo) send_word(1'($urandom_range(1, 0)), 1'b0, '0);
      end else begin
        if (roll < 20)
          hi = $urandom_range(260, 60);
        else
          hi = $urandom_range(45, 1);
        lo = $urandom_range(30, 1);
        repeat (lo) send_word(1'b0, 1'b0, '0);
        repeat (hi) send_word(1'b1, 1'b0, '0);
      end
    end
  endtask

  initial begin
    echo_if.valid      = 1'b0;
    echo_if.echo_level = 1'b0;
    res_if.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Before the first trigger: nothing gets scheduled, only edges are timed.
    program_regs(CFG_W'(90), '0, TRIGW_TOP, CFG_TOP);
    for (int i = 0; i < PROBE_N; i++)
      send_word(probe_tab[i].echo, probe_tab[i].typed, probe_tab[i].want);
    run_phase(880);
    drain();

    // First trigger falls in here; short period so long echoes take the gap.
    program_regs(CFG_W'(60), CFG_W'(7), TRIG_W'(12), '0);
    run_phase(120);
    drain();

    // Zero period and zero gap give one-tick waits; zero width gives no pulse.
    program_regs('0, '0, '0, CFG_W'(1));
    run_phase(120);
    drain();

    // One-tick waits against the widest pulse: retrigger while it runs.
    program_regs(CFG_W'(1), CFG_W'(1), TRIGW_TOP, CFG_W'(5000));
    run_phase(120);
    drain();

    repeat (2) begin
      program_regs(CFG_W'($urandom_range(300, 2)), CFG_W'($urandom_range(120, 0)),
                   TRIG_W'($urandom_range(255, 0)), CFG_W'($urandom));
      run_phase(120);
      drain();
    end

    // Widest period last: its wait stays pending for the rest of the run.
    program_regs(CFG_TOP, CFG_TOP, TRIG_W'(1), CFG_W'(77));
    run_phase(120);
    drain();

    if (mismatches == 0 && reg_faults == 0)
      $display("tb_ultrasonic_echo_ranger_core: clean");
    else
      $display("tb_ultrasonic_echo_ranger_core: errors");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(LIMIT_TU);
    $display("tb_ultrasonic_echo_ranger_core: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/uer_pkg.sv
design/uer_in_if.sv
design/uer_out_if.sv
design/uer_skid.sv
design/ultrasonic_echo_ranger_core.sv
design/uer_checker.sv
verif/tb_ultrasonic_echo_ranger_core.sv
